// ===== design/hiwal_pkg.sv =====
// Shared constants, slot word layout and controller/datapath handshake structs.
package hiwal_pkg;

    localparam int KEY_W    = 64;
    localparam int OFF_W    = 32;
    localparam int LEN_W    = 13;
    localparam int STATUS_W = 3;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_LENGTH = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd3;
    localparam logic [STATUS_W-1:0] ST_LOG_FULL   = 3'd4;

    // Every record in the log carries a fixed header ahead of its payload.
    localparam int HEADER_BYTES = 12;

    // Home slot reduction consumes this many fingerprint bits per cycle.
    localparam int MOD_DIGIT_W = 8;
    localparam int MOD_STEPS   = KEY_W / MOD_DIGIT_W;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [OFF_W-1:0] offset;
        logic [LEN_W-1:0] length;
    } slot_t;

    typedef struct packed {
        logic accept;
        logic clear;
        logic check;
        logic mod_step;
        logic probe_start;
        logic probe_step;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic early_done;
        logic skip_mod;
        logic mod_last;
        logic probe_done;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== design/hiwal_if.sv =====
// Request and response channel interfaces with valid/ready handshake.
interface hiwal_req_if;
    logic                           valid;
    logic                           ready;
    logic                           command;
    logic [hiwal_pkg::KEY_W-1:0]    key_fingerprint;
    logic [hiwal_pkg::LEN_W-1:0]    value_length;

    modport source (output valid, output command, output key_fingerprint,
                    output value_length, input ready);
    modport sink   (input valid, input command, input key_fingerprint,
                    input value_length, output ready);
endinterface

interface hiwal_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [hiwal_pkg::STATUS_W-1:0] status;
    logic [hiwal_pkg::OFF_W-1:0]    record_offset;
    logic [hiwal_pkg::LEN_W-1:0]    record_length;

    modport source (output valid, output status, output record_offset,
                    output record_length, input ready);
    modport sink   (input valid, input status, input record_offset,
                    input record_length, output ready);
endinterface

// ===== design/hash_index_with_append_log.sv =====
// Top level of the linear probing hash index with append log offset allocator.
//
// Each request beat is an insert or a lookup of a 64-bit key fingerprint and
// produces exactly one response beat. After reset the block runs a clearing
// pass over the slot store, one slot per cycle, and keeps req.ready low
// until it is done. An insert first checks the length (1 to MAX_VALUE) and
// that the log end plus the 12-byte header and payload stays within 32 bits,
// then reserves that space and probes linearly from fingerprint mod SLOTS;
// it takes the first empty slot or the slot holding the same fingerprint. A
// lookup stops at a match, an empty slot, or after a full circle. The block
// takes one item at a time. The probe reads one slot per cycle from the
// slot memory, whose read data is registered before the compare. When SLOTS
// is not a power of two the home slot is reduced eight fingerprint bits per
// cycle before the probe starts. A rejected insert (bad length or log full)
// skips the probe and goes from the check straight to the response. The
// block raises req.ready again at the same edge that loads the result into
// the response register. A finished response waits in its own register, so
// the block returns to accepting while the previous beat is still unclaimed;
// it only stalls when a second result is ready before the first is taken.
module hash_index_with_append_log #(
    parameter int SLOTS     = 1024,
    parameter int MAX_VALUE = 4096
) (
    input  logic         clk,
    input  logic         rst_n,
    hiwal_req_if.sink    req,
    hiwal_rsp_if.source  rsp
);
    import hiwal_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequence each item: check, reduce, probe, respond
    hiwal_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // hold the item, log end, slot memory and response register
    hiwal_dp #(
        .SLOTS     (SLOTS),
        .MAX_VALUE (MAX_VALUE)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .req_command (req.command),
        .req_key     (req.key_fingerprint),
        .req_length  (req.value_length),
        .rsp_ready   (rsp.ready),
        .rsp_valid   (rsp.valid),
        .rsp_status  (rsp.status),
        .rsp_offset  (rsp.record_offset),
        .rsp_length  (rsp.record_length)
    );

endmodule

// ===== design/hiwal_ctrl.sv =====
// Sequencer for clear pass, admission checks, home slot reduction and probing.
module hiwal_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  hiwal_pkg::dp_stat_t stat,
    output hiwal_pkg::dp_cmd_t  cmd
);
    import hiwal_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_MOD,
        S_START,
        S_PROBE,
        S_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   req_ready_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clear_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (req_valid && req_ready_reg)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.check = 1'b1;
                if (stat.early_done)
                    state_next = S_RESP;
                else if (stat.skip_mod)
                    state_next = S_START;
                else
                    state_next = S_MOD;
            end
            S_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (stat.mod_last)
                    state_next = S_START;
            end
            S_START:
            begin
                cmd.probe_start = 1'b1;
                state_next      = S_PROBE;
            end
            S_PROBE:
            begin
                cmd.probe_step = 1'b1;
                if (stat.probe_done)
                    state_next = S_RESP;
            end
            S_RESP:
            begin
                // hold the result until the output register can take it
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            req_ready_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            req_ready_reg <= (state_next == S_IDLE);
        end
    end

    assign req_ready = req_ready_reg;

endmodule

// ===== design/hiwal_dp.sv =====
// Datapath: item registers, log end, home slot reduction, slot memory, result regs.
module hiwal_dp #(
    parameter int SLOTS     = 1024,
    parameter int MAX_VALUE = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  hiwal_pkg::dp_cmd_t              cmd,
    output hiwal_pkg::dp_stat_t             stat,
    input  logic                            req_command,
    input  logic [hiwal_pkg::KEY_W-1:0]     req_key,
    input  logic [hiwal_pkg::LEN_W-1:0]     req_length,
    input  logic                            rsp_ready,
    output logic                            rsp_valid,
    output logic [hiwal_pkg::STATUS_W-1:0]  rsp_status,
    output logic [hiwal_pkg::OFF_W-1:0]     rsp_offset,
    output logic [hiwal_pkg::LEN_W-1:0]     rsp_length
);
    import hiwal_pkg::*;

    localparam int   IDX_W    = $clog2(SLOTS);
    localparam int   CNT_W    = $clog2(SLOTS + 1);
    localparam int   REM_W    = IDX_W + 1;
    localparam int   STEP_W   = $clog2(MOD_STEPS);
    localparam int   END_W    = OFF_W + 1;
    localparam int   MAXV_W   = $clog2(MAX_VALUE + 1);
    localparam int   CMP_W    = (MAXV_W > LEN_W) ? MAXV_W : LEN_W;
    localparam logic IS_POW2  = ((SLOTS & (SLOTS - 1)) == 0);

    // item registers
    logic              cmd_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [OFF_W-1:0]  off_reg;
    logic [OFF_W-1:0]  log_end_reg;

    // home slot reduction
    logic [IDX_W-1:0]  rem_reg;
    logic [IDX_W-1:0]  rem_next;
    logic [REM_W-1:0]  trial;
    logic [KEY_W-1:0]  mod_sh_reg;
    logic [STEP_W-1:0] mod_cnt_reg;

    // probe state
    logic [IDX_W-1:0]  clr_addr_reg;
    logic [IDX_W-1:0]  issue_addr_reg;
    logic [IDX_W-1:0]  cmp_addr_reg;
    logic [CNT_W-1:0]  issued_cnt_reg;
    logic              cmp_valid_reg;
    logic              issue_ok;
    slot_t             rd_word_reg;
    logic              slot_empty;
    logic              slot_match;
    logic              hit;
    logic              exhausted;
    logic [IDX_W-1:0]  home_idx;

    // memory write port
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    slot_t             wr_word;
    slot_t             slot_mem [SLOTS];

    // admission checks
    logic              bad_len;
    logic [END_W-1:0]  new_end;
    logic              log_full;
    logic              early;

    // result and output registers
    logic [STATUS_W-1:0] res_status_reg;
    logic [OFF_W-1:0]    res_off_reg;
    logic [LEN_W-1:0]    res_len_reg;
    logic                rsp_valid_reg;
    logic [STATUS_W-1:0] rsp_status_reg;
    logic [OFF_W-1:0]    rsp_offset_reg;
    logic [LEN_W-1:0]    rsp_length_reg;

    assign bad_len  = (len_reg == '0) || (CMP_W'(len_reg) > CMP_W'(MAX_VALUE));
    assign new_end  = END_W'(log_end_reg) + END_W'(HEADER_BYTES) + END_W'(len_reg);
    assign log_full = new_end[OFF_W];
    assign early    = (cmd_reg == CMD_INSERT) && (bad_len || log_full);

    // shift-subtract remainder, one digit of the fingerprint per cycle
    always_comb
    begin
        rem_next = rem_reg;
        trial    = '0;
        for (int b = 0; b < MOD_DIGIT_W; b++)
        begin
            trial = {rem_next, mod_sh_reg[KEY_W-1-b]};
            if (trial >= REM_W'(SLOTS))
                trial = trial - REM_W'(SLOTS);
            rem_next = trial[IDX_W-1:0];
        end
    end

    assign home_idx   = IS_POW2 ? key_reg[IDX_W-1:0] : rem_reg;
    assign issue_ok   = (issued_cnt_reg < CNT_W'(SLOTS));
    assign slot_empty = (rd_word_reg.key == '0);
    assign slot_match = (rd_word_reg.key == key_reg);
    assign hit        = cmp_valid_reg && (slot_empty || slot_match);
    assign exhausted  = !cmp_valid_reg && (issued_cnt_reg == CNT_W'(SLOTS));

    assign wr_en   = cmd.clear || (cmd.probe_step && hit && (cmd_reg == CMD_INSERT));
    assign wr_addr = cmd.clear ? clr_addr_reg : cmp_addr_reg;
    assign wr_word = cmd.clear ? slot_t'('0) : slot_t'{key: key_reg, offset: off_reg,
                                                       length: len_reg};

    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_mem[wr_addr] <= wr_word;
        rd_word_reg <= slot_mem[issue_addr_reg];
    end

    // item, log end and reduction registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log_end_reg  <= '0;
            clr_addr_reg <= '0;
            mod_cnt_reg  <= '0;
        end
        else
        begin
            if (cmd.clear)
                clr_addr_reg <= (clr_addr_reg == IDX_W'(SLOTS - 1)) ? '0
                                                                    : clr_addr_reg + 1'b1;
            if (cmd.check && !early && (cmd_reg == CMD_INSERT))
                log_end_reg <= new_end[OFF_W-1:0];
            if (cmd.check)
                mod_cnt_reg <= '0;
            else if (cmd.mod_step)
                mod_cnt_reg <= mod_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cmd_reg <= req_command;
            key_reg <= req_key;
            len_reg <= req_length;
        end
        if (cmd.check)
        begin
            off_reg    <= log_end_reg;
            rem_reg    <= '0;
            mod_sh_reg <= key_reg;
        end
        else if (cmd.mod_step)
        begin
            rem_reg    <= rem_next;
            mod_sh_reg <= mod_sh_reg << MOD_DIGIT_W;
        end
    end

    // probe address generation
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_valid_reg  <= 1'b0;
            issued_cnt_reg <= '0;
        end
        else if (cmd.probe_start)
        begin
            cmp_valid_reg  <= 1'b0;
            issued_cnt_reg <= '0;
        end
        else if (cmd.probe_step)
        begin
            cmp_valid_reg <= issue_ok;
            if (issue_ok)
                issued_cnt_reg <= issued_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.probe_start)
            issue_addr_reg <= home_idx;
        else if (cmd.probe_step)
        begin
            cmp_addr_reg   <= issue_addr_reg;
            issue_addr_reg <= (issue_addr_reg == IDX_W'(SLOTS - 1)) ? '0
                                                                    : issue_addr_reg + 1'b1;
        end
    end

    // result capture
    always_ff @(posedge clk)
    begin
        if (cmd.check && early)
        begin
            res_status_reg <= bad_len ? ST_BAD_LENGTH : ST_LOG_FULL;
            res_off_reg    <= '0;
            res_len_reg    <= '0;
        end
        else if (cmd.probe_step && (hit || exhausted))
        begin
            if (cmd_reg == CMD_INSERT)
            begin
                res_status_reg <= hit ? ST_OK : ST_TABLE_FULL;
                res_off_reg    <= off_reg;
                res_len_reg    <= len_reg;
            end
            else if (hit && !slot_empty)
            begin
                res_status_reg <= ST_OK;
                res_off_reg    <= rd_word_reg.offset;
                res_len_reg    <= rd_word_reg.length;
            end
            else
            begin
                res_status_reg <= ST_NOT_FOUND;
                res_off_reg    <= '0;
                res_len_reg    <= '0;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (cmd.load_out)
            rsp_valid_reg <= 1'b1;
        else if (rsp_ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            rsp_status_reg <= res_status_reg;
            rsp_offset_reg <= res_off_reg;
            rsp_length_reg <= res_len_reg;
        end
    end

    assign rsp_valid  = rsp_valid_reg;
    assign rsp_status = rsp_status_reg;
    assign rsp_offset = rsp_offset_reg;
    assign rsp_length = rsp_length_reg;

    assign stat.clear_last = (clr_addr_reg == IDX_W'(SLOTS - 1));
    assign stat.early_done = early;
    assign stat.skip_mod   = IS_POW2;
    assign stat.mod_last   = (mod_cnt_reg == STEP_W'(MOD_STEPS - 1));
    assign stat.probe_done = hit || exhausted;
    assign stat.out_free   = !rsp_valid_reg || rsp_ready;

    a_log_end_moves_on_check: assert property (@(posedge clk) disable iff (!rst_n)
        (log_end_reg != $past(log_end_reg)) |-> $past(cmd.check))
        else $error("log end changed outside an admission check");

    a_rsp_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(cmd.load_out))
        else $error("response raised without a result load");

    a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!rsp_valid_reg || rsp_ready))
        else $error("result loaded over a pending response");

    a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
        issued_cnt_reg <= CNT_W'(SLOTS))
        else $error("probe issued past a full circle");

endmodule
